// ===== design/hts_pkg.sv =====
// Shared types, constants and the level threshold table for the HDR sRGB encoder.
package hts_pkg;

    localparam int unsigned CH_W      = 32;
    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned LEVELS    = 255;
    localparam int unsigned LIN_STEPS = 10;
    localparam int unsigned SRCH_STG  = 8;
    localparam logic [63:0] Q30_ONE   = 64'd1 << 30;
    localparam logic signed [CH_W-1:0] Q16_ONE = 32'sd65536;

    typedef struct packed {
        logic signed [CH_W-1:0] red_in;
        logic signed [CH_W-1:0] green_in;
        logic signed [CH_W-1:0] blue_in;
    } t_pix_in;

    typedef struct packed {
        logic [BYTE_W-1:0] blue_out;
        logic [BYTE_W-1:0] green_out;
        logic [BYTE_W-1:0] red_out;
    } t_pix_out;

    typedef logic [CH_W-1:0] t_thr_tab [0:LEVELS];

    // r^5 in Q30, truncating after each product.
    function automatic logic [63:0] fifth_q30(input logic [63:0] r);
        logic [63:0] r2;
        logic [63:0] r4;
        r2 = (r * r) >> 30;
        r4 = (r2 * r2) >> 30;
        return (r4 * r) >> 30;
    endfunction

    // Shift-subtract division, elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [63:0] q;
        logic [63:0] rem;
        q   = '0;
        rem = '0;
        for (int i = 63; i >= 0; i--) begin
            rem = {rem[62:0], n[i]};
            if (rem >= d) begin
                rem  = rem - d;
                q[i] = 1'b1;
            end
        end
        return q;
    endfunction

    // Smallest Q16 input reaching each output level; entry 0 unused.
    function automatic t_thr_tab build_thr();
        t_thr_tab    tab;
        logic [63:0] odd;
        logic [63:0] lin;
        logic [63:0] a;
        logic [63:0] s;
        logic [63:0] r;
        logic [63:0] cand;
        logic [63:0] q;
        tab[0] = '0;
        for (int k = 1; k <= LEVELS; k++) begin
            odd = 64'(2 * k - 1);
            if (k <= LIN_STEPS) begin
                lin = ((odd * 64'd100) << 30) / 64'd658920;
            end else begin
                a = ((odd * 64'd1000 + 64'd28050) << 30) / 64'd538050;
                s = (a * a) >> 30;
                r = '0;
                for (int b = 30; b >= 0; b--) begin
                    cand = r | (64'd1 << b);
                    if (cand <= Q30_ONE && fifth_q30(cand) <= s) begin
                        r = cand;
                    end
                end
                lin = (s * r) >> 30;
            end
            q = udiv64((lin << 16) + (Q30_ONE - lin) - 64'd1, Q30_ONE - lin);
            tab[k] = q[CH_W-1:0];
        end
        return tab;
    endfunction

    localparam t_thr_tab THR = build_thr();

endpackage

// ===== design/hts_lane.sv =====
// One color channel: plain scaling plus an 8-stage binary search over the level thresholds.
module hts_lane (
    input  logic                              i_clk,
    input  logic                              i_en,
    input  logic                              i_hdr,
    input  logic signed [hts_pkg::CH_W-1:0]   i_x,
    output logic [hts_pkg::BYTE_W-1:0]        o_byte
);

    localparam int unsigned NS = hts_pkg::SRCH_STG;

    logic [hts_pkg::CH_W-1:0]   r_x     [0:NS-1];
    logic [hts_pkg::BYTE_W-1:0] r_r     [0:NS-1];
    logic                       r_zero  [0:NS-1];
    logic                       r_hdr   [0:NS-1];
    logic [hts_pkg::BYTE_W-1:0] r_plain [0:NS-1];

    logic [hts_pkg::CH_W-1:0]   w_x_in  [0:NS-1];
    logic [hts_pkg::BYTE_W-1:0] w_r_in  [0:NS-1];
    logic [hts_pkg::BYTE_W-1:0] n_r     [0:NS-1];
    logic [hts_pkg::BYTE_W-1:0] w_plain;
    logic [24:0]                w_prod;

    // Plain mode: clamp to one, scale by 255 and round half up.
    always_comb begin
        w_prod = 25'(i_x[16:0]) * 25'd255 + 25'd32768;
        if (i_x >= hts_pkg::Q16_ONE) begin
            w_plain = 8'd255;
        end else begin
            w_plain = w_prod[23:16];
        end
    end

    always_comb begin
        w_x_in[0] = i_x;
        w_r_in[0] = '0;
        for (int j = 1; j < NS; j++) begin
            w_x_in[j] = r_x[j-1];
            w_r_in[j] = r_r[j-1];
        end
    end

    for (genvar j = 0; j < NS; j++) begin : g_stage
        logic [hts_pkg::BYTE_W-1:0] w_cand;
        assign w_cand = w_r_in[j] | (8'd1 << (NS - 1 - j));
        assign n_r[j] = (hts_pkg::THR[w_cand] <= w_x_in[j]) ? w_cand : w_r_in[j];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_x[0]     <= i_x;
            r_r[0]     <= n_r[0];
            r_zero[0]  <= (i_x <= 0);
            r_hdr[0]   <= i_hdr;
            r_plain[0] <= w_plain;
            for (int j = 1; j < NS; j++) begin
                r_x[j]     <= r_x[j-1];
                r_r[j]     <= n_r[j];
                r_zero[j]  <= r_zero[j-1];
                r_hdr[j]   <= r_hdr[j-1];
                r_plain[j] <= r_plain[j-1];
            end
        end
    end

    assign o_byte = r_zero[NS-1] ? '0 : (r_hdr[NS-1] ? r_r[NS-1] : r_plain[NS-1]);

endmodule

// ===== design/hdr_tonemap_srgb_encode.sv =====
// Top level: three channel lanes, valid pipeline and the merged output register.
// Converts one linear RGB pixel (signed Q15.16 per channel) to a BGR byte triple.
// With hdr_mode set, each channel is clipped at zero, Reinhard tone mapped and
// sRGB encoded; the curve is realized as a binary search over 255 constant
// thresholds, one bit of the level per stage. With hdr_mode clear, the channel
// is clamped to [0,1], scaled by 255 and rounded half up. One pixel enters per
// clock unless the pipeline holds; the accepting edge loads the first of 8
// search stages, and the output register follows the last stage. The whole
// pipeline advances together and holds only while a finished pixel waits at
// the output.
// hdr_mode is sampled per item on entry.
module hdr_tonemap_srgb_encode (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_wr_en,
    input  logic              i_cfg_wr_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  hts_pkg::t_pix_in  i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output hts_pkg::t_pix_out o_out_data
);

    localparam int unsigned NS = hts_pkg::SRCH_STG;

    logic                      r_hdr_mode;
    logic [NS-1:0]             r_vld;
    logic                      r_out_valid;
    hts_pkg::t_pix_out         r_out_data;
    logic                      w_en;
    logic [hts_pkg::BYTE_W-1:0] w_red;
    logic [hts_pkg::BYTE_W-1:0] w_green;
    logic [hts_pkg::BYTE_W-1:0] w_blue;

    // Advance everything unless the output holds an item not yet taken.
    assign w_en       = !(r_out_valid && !i_out_ready);
    assign o_in_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_mode <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_hdr_mode <= i_cfg_wr_data;
        end
    end

    hts_lane u_lane_r (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_hdr  (r_hdr_mode),
        .i_x    (i_in_data.red_in),
        .o_byte (w_red)
    );

    hts_lane u_lane_g (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_hdr  (r_hdr_mode),
        .i_x    (i_in_data.green_in),
        .o_byte (w_green)
    );

    hts_lane u_lane_b (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_hdr  (r_hdr_mode),
        .i_x    (i_in_data.blue_in),
        .o_byte (w_blue)
    );

    // Valid bits track items through the search stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld       <= '0;
            r_out_valid <= 1'b0;
        end else if (w_en) begin
            r_vld       <= {r_vld[NS-2:0], i_in_valid};
            r_out_valid <= r_vld[NS-1];
        end
    end

    // Merge the lane bytes into the BGR output item.
    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out_data.blue_out  <= w_blue;
            r_out_data.green_out <= w_green;
            r_out_data.red_out   <= w_red;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

// ===== design/hts_checker.sv =====
// Port-level checks for the HDR sRGB encoder, bound to the top level.
module hts_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              o_in_ready,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input hts_pkg::t_pix_out o_out_data
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_data))
        else $error("output item changed while stalled");

    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

endmodule

bind hdr_tonemap_srgb_encode hts_checker u_hts_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
